// File: hdl/crubio_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crubio_pkg;

  typedef enum logic [2:0] {
    OP_CRU_RD  = 3'd0,
    OP_CRU_WR  = 3'd1,
    OP_SET_IN  = 3'd2,
    OP_SET_OVL = 3'd3,
    OP_RD_IN   = 3'd4,
    OP_RD_OUT  = 3'd5,
    OP_PENDANT = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    REG_IN_BASE  = 2'd0,
    REG_IN_LAST  = 2'd1,
    REG_OUT_BASE = 2'd2,
    REG_OUT_LAST = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] cru_addr;
    logic [7:0]  terminal;
    logic [1:0]  card_number;
    logic        bit_value;
    logic [4:0]  buttons;
  } in_item_t;

  typedef struct packed {
    logic read_bit;
    logic accepted;
  } out_item_t;

  localparam logic [15:0] IN_BASE_RST  = 16'd0;
  localparam logic [15:0] IN_LAST_RST  = 16'd255;
  localparam logic [15:0] OUT_BASE_RST = 16'd0;
  localparam logic [15:0] OUT_LAST_RST = 16'd127;

  // Channel map: 64 input slots and 32 output slots per card.
  localparam logic [5:0]  CH_OVL_OK    = 6'd63;
  localparam logic [4:0]  CH_STROBE    = 5'd31;
  localparam logic [15:0] OUT_FEEDBACK = 16'd6;
  localparam int unsigned OUT_FB_CH    = 6;
  localparam int unsigned IN_FEEDBACK  = 20;
  localparam int unsigned IN_STOP_N    = 23;
  localparam int unsigned IN_START     = 22;
  localparam int unsigned IN_RAPID     = 21;
  localparam int unsigned IN_MANUAL    = 19;
  localparam int unsigned IN_FEED_EN   = 18;

endpackage

`default_nettype wire

// File: hdl/cru_bit_io_backplane.sv
// CRU bit I/O backplane.
// Input channel in_valid/in_ready/in_data carries one operation per transaction:
// CRU read or write through the input/output address windows, machine-side
// updates (input terminal, overload flag, pendant buttons) and direct terminal
// reads. Each transaction returns exactly one result on out_valid/out_ready/
// out_data (read_bit, accepted).
// Configuration: cfg_we writes cfg_data into the window register cfg_index;
// write only while no transaction is in flight.
// An accepted transaction passes the input register, then the result
// register. Throughput: one transaction per cycle unless out_ready stalls, set
// by the single pass of decode and update logic between the two registers.
// Stall: while out_valid is held by a low out_ready the input register still
// takes one transaction; in_ready drops only when both registers are full.
// Reset (synchronous, rst_n low): both registers empty, windows at 0..255 and
// 0..127, all outputs 0, all overload-ok flags set, card 0 inputs 18 (feed
// enable) and 23 (stop not pressed) set, all other inputs 0.
`timescale 1ns / 1ps
`default_nettype none

module cru_bit_io_backplane #(
  parameter int CARDS            = 4,
  parameter int INPUTS_PER_CARD  = 63,
  parameter int OUTPUTS_PER_CARD = 31
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire crubio_pkg::in_item_t in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output crubio_pkg::out_item_t     out_data,
  input  wire logic                 cfg_we,
  input  wire crubio_pkg::cfg_reg_t cfg_index,
  input  wire logic [15:0]          cfg_data
);
  import crubio_pkg::*;

  localparam int CW = (CARDS > 1) ? $clog2(CARDS) : 1;
  localparam int IW = $clog2(INPUTS_PER_CARD);
  localparam int OW = $clog2(OUTPUTS_PER_CARD);
  localparam logic [15:0] CARDS_W = 16'(CARDS);
  localparam logic [5:0]  N_IN    = 6'(INPUTS_PER_CARD);
  localparam logic [4:0]  N_OUT   = 5'(OUTPUTS_PER_CARD);
  localparam logic [INPUTS_PER_CARD-1:0] IN_ONE  = {{(INPUTS_PER_CARD-1){1'b0}}, 1'b1};
  localparam logic [INPUTS_PER_CARD-1:0] IN0_RST = (IN_ONE << IN_FEED_EN) |
                                                   (IN_ONE << IN_STOP_N);

  logic [15:0] in_base_r, in_last_r, out_base_r, out_last_r;

  logic [INPUTS_PER_CARD-1:0]  in_bits_r  [CARDS];
  logic [INPUTS_PER_CARD-1:0]  in_bits_nxt [CARDS];
  logic [OUTPUTS_PER_CARD-1:0] out_bits_r [CARDS];
  logic [OUTPUTS_PER_CARD-1:0] out_bits_nxt [CARDS];
  logic [CARDS-1:0]            ovl_ok_r, ovl_ok_nxt;

  in_item_t  in_q_r;
  logic      in_vld_r;
  out_item_t out_q_r, res_nxt;
  logic      out_vld_r;
  logic      adv;

  logic        in_win_ok, out_win_ok;
  logic [15:0] in_off, out_off, rd_in_idx, term_idx, cn_idx;
  logic        ri_card_ok, ro_card_ok, wo_card_ok, ti_card_ok, cn_ok;
  logic [5:0]  ri_ch, ti_ch;
  logic [4:0]  ro_ch, wo_ch;
  logic        in_rd_bit, out_rd_bit;

  assign adv       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || adv;
  assign out_valid = out_vld_r;
  assign out_data  = out_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_r <= in_data;
    end
    if (adv) begin
      out_q_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_base_r  <= IN_BASE_RST;
      in_last_r  <= IN_LAST_RST;
      out_base_r <= OUT_BASE_RST;
      out_last_r <= OUT_LAST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_BASE:  in_base_r  <= cfg_data;
        REG_IN_LAST:  in_last_r  <= cfg_data;
        REG_OUT_BASE: out_base_r <= cfg_data;
        REG_OUT_LAST: out_last_r <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CARDS; c++) begin
        in_bits_r[c]  <= (c == 0) ? IN0_RST : '0;
        out_bits_r[c] <= '0;
      end
      ovl_ok_r <= '1;
    end else if (adv) begin
      for (int c = 0; c < CARDS; c++) begin
        in_bits_r[c]  <= in_bits_nxt[c];
        out_bits_r[c] <= out_bits_nxt[c];
      end
      ovl_ok_r <= ovl_ok_nxt;
    end
  end

  // Address decode
  assign in_win_ok  = (in_q_r.cru_addr >= in_base_r) && (in_q_r.cru_addr <= in_last_r);
  assign out_win_ok = (in_q_r.cru_addr >= out_base_r) &&
                      (in_q_r.cru_addr <= out_last_r);
  assign in_off     = in_q_r.cru_addr - in_base_r;
  assign out_off    = in_q_r.cru_addr - out_base_r;
  assign term_idx   = {8'd0, in_q_r.terminal};
  assign cn_idx     = {14'd0, in_q_r.card_number};
  assign rd_in_idx  = (in_q_r.op == OP_CRU_RD) ? in_off : term_idx;

  assign ri_card_ok = {6'd0, rd_in_idx[15:6]} < CARDS_W;
  assign ri_ch      = rd_in_idx[5:0];
  assign ro_card_ok = {5'd0, term_idx[15:5]} < CARDS_W;
  assign ro_ch      = term_idx[4:0];
  assign wo_card_ok = {5'd0, out_off[15:5]} < CARDS_W;
  assign wo_ch      = out_off[4:0];
  assign ti_card_ok = {6'd0, term_idx[15:6]} < CARDS_W;
  assign ti_ch      = term_idx[5:0];
  assign cn_ok      = cn_idx < CARDS_W;

  always_comb begin
    in_rd_bit = 1'b0;
    if (ri_card_ok) begin
      if (ri_ch == CH_OVL_OK) begin
        in_rd_bit = ovl_ok_r[rd_in_idx[6 +: CW]];
      end else if (ri_ch < N_IN) begin
        in_rd_bit = in_bits_r[rd_in_idx[6 +: CW]][ri_ch[IW-1:0]];
      end
    end
  end

  always_comb begin
    out_rd_bit = 1'b0;
    if (ro_card_ok && (ro_ch < N_OUT)) begin
      out_rd_bit = out_bits_r[term_idx[5 +: CW]][ro_ch[OW-1:0]];
    end
  end

  always_comb begin
    for (int c = 0; c < CARDS; c++) begin
      in_bits_nxt[c]  = in_bits_r[c];
      out_bits_nxt[c] = out_bits_r[c];
    end
    ovl_ok_nxt = ovl_ok_r;
    res_nxt.read_bit = 1'b0;
    res_nxt.accepted = 1'b1;
    unique case (in_q_r.op)
      OP_CRU_RD: begin
        res_nxt.accepted = in_win_ok;
        res_nxt.read_bit = in_win_ok && in_rd_bit;
      end
      OP_CRU_WR: begin
        res_nxt.accepted = out_win_ok;
        if (out_win_ok && wo_card_ok) begin
          if (wo_ch == CH_STROBE) begin
            if (in_q_r.bit_value) begin
              ovl_ok_nxt[out_off[5 +: CW]] = 1'b1;
            end
          end else if (wo_ch < N_OUT) begin
            out_bits_nxt[out_off[5 +: CW]][wo_ch[OW-1:0]] = in_q_r.bit_value;
            if (out_off == OUT_FEEDBACK) begin
              in_bits_nxt[0][IN_FEEDBACK] = in_q_r.bit_value;
            end
          end
        end
      end
      OP_SET_IN: begin
        if (ti_card_ok && (ti_ch < N_IN)) begin
          in_bits_nxt[term_idx[6 +: CW]][ti_ch[IW-1:0]] = in_q_r.bit_value;
        end
      end
      OP_SET_OVL: begin
        if (cn_ok) begin
          ovl_ok_nxt[cn_idx[CW-1:0]] = !in_q_r.bit_value;
        end
      end
      OP_RD_IN:  res_nxt.read_bit = in_rd_bit;
      OP_RD_OUT: res_nxt.read_bit = out_rd_bit;
      OP_PENDANT: begin
        in_bits_nxt[0][IN_STOP_N]   = !in_q_r.buttons[0];
        in_bits_nxt[0][IN_START]    = in_q_r.buttons[1];
        in_bits_nxt[0][IN_RAPID]    = in_q_r.buttons[2];
        in_bits_nxt[0][IN_MANUAL]   = in_q_r.buttons[3];
        in_bits_nxt[0][IN_FEED_EN]  = in_q_r.buttons[4];
        in_bits_nxt[0][IN_FEEDBACK] = out_bits_r[0][OUT_FB_CH];
      end
      default: ;
    endcase
  end

  a_refused_read: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (in_q_r.op == OP_CRU_RD) && !in_win_ok |=> !out_q_r.accepted && !out_q_r.read_bit)
    else $error("refused CRU read returned data or accept");

  a_other_ops_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (in_q_r.op != OP_CRU_RD) && (in_q_r.op != OP_CRU_WR) |=> out_q_r.accepted)
    else $error("non-CRU transaction not accepted");

  a_overload_card0: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (in_q_r.op == OP_SET_OVL) && (in_q_r.card_number == 2'd0)
    |=> ovl_ok_r[0] == !$past(in_q_r.bit_value))
    else $error("overload flag of card 0 not updated");

  a_feedback: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (in_q_r.op == OP_CRU_WR) && out_win_ok && (out_off == OUT_FEEDBACK)
    |=> in_bits_r[0][IN_FEEDBACK] == $past(in_q_r.bit_value))
    else $error("output 6 not fed back to input 20");

  a_pendant_stop: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (in_q_r.op == OP_PENDANT)
    |=> in_bits_r[0][IN_STOP_N] == !$past(in_q_r.buttons[0]))
    else $error("pendant stop input not inverted");

endmodule

`default_nettype wire

// File: tb/sv/cru_bit_io_backplane_tb.sv
`timescale 1ns / 1ps

module cru_bit_io_backplane_tb;
  import crubio_pkg::*;

  localparam int NUM_CARDS = 4;
  localparam int IN_CH = 63;
  localparam int OUT_CH = 31;
  localparam logic [2:0] OP_NONE = 3'd7;
  localparam int unsigned LIMIT_CYCLES = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  cfg_reg_t cfg_index = REG_IN_BASE;
  logic [15:0] cfg_data = 16'd0;

  // backplane image
  logic [IN_CH-1:0] in_bits[NUM_CARDS];
  logic [OUT_CH-1:0] out_bits[NUM_CARDS];
  logic [NUM_CARDS-1:0] ovl_ok;
  logic [15:0] win_in_base, win_in_last, win_out_base, win_out_last;

  out_item_t io_results_due[$];
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned n_settings = 0;
  int unsigned cycles = 0;
  int unsigned gap_pct = 20;
  int unsigned stall_pct = 20;
  int unsigned stall_left = 0;
  bit quiet = 1'b0;

  cru_bit_io_backplane u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results still due", cycles,
               io_results_due.size());
      $display("FAIL cru_bit_io_backplane");
      $finish;
    end
  end

  // ---------------- backplane image ----------------
  function automatic void clear_backplane();
    for (int c = 0; c < NUM_CARDS; c++) begin
      in_bits[c] = '0;
      out_bits[c] = '0;
    end
    ovl_ok = '1;
    in_bits[0][IN_STOP_N] = 1'b1;
    in_bits[0][IN_FEED_EN] = 1'b1;
    win_in_base = IN_BASE_RST;
    win_in_last = IN_LAST_RST;
    win_out_base = OUT_BASE_RST;
    win_out_last = OUT_LAST_RST;
  endfunction

  function automatic logic input_level(int unsigned idx);
    int unsigned card, ch;
    card = idx / 64;
    ch = idx % 64;
    if (card >= NUM_CARDS) return 1'b0;
    if (ch == CH_OVL_OK) return ovl_ok[card];
    if (ch >= IN_CH) return 1'b0;
    return in_bits[card][ch];
  endfunction

  function automatic logic output_level(int unsigned idx);
    int unsigned card, ch;
    card = idx / 32;
    ch = idx % 32;
    if (card >= NUM_CARDS || ch >= OUT_CH) return 1'b0;
    return out_bits[card][ch];
  endfunction

  function automatic void drive_output(int unsigned idx, logic v);
    int unsigned card, ch;
    card = idx / 32;
    ch = idx % 32;
    if (card >= NUM_CARDS) return;
    if (ch == CH_STROBE) begin
      if (v) ovl_ok[card] = 1'b1;
      return;
    end
    if (ch >= OUT_CH) return;
    out_bits[card][ch] = v;
    if (idx == OUT_FEEDBACK) in_bits[0][IN_FEEDBACK] = v;
  endfunction

  function automatic out_item_t backplane_step(in_item_t t);
    out_item_t r;
    int unsigned card, ch;
    r.read_bit = 1'b0;
    r.accepted = 1'b1;
    case (t.op)
      OP_CRU_RD: begin
        if (t.cru_addr < win_in_base || t.cru_addr > win_in_last) r.accepted = 1'b0;
        else r.read_bit = input_level(t.cru_addr - win_in_base);
      end
      OP_CRU_WR: begin
        if (t.cru_addr < win_out_base || t.cru_addr > win_out_last) r.accepted = 1'b0;
        else drive_output(t.cru_addr - win_out_base, t.bit_value);
      end
      OP_SET_IN: begin
        card = t.terminal / 64;
        ch = t.terminal % 64;
        if (card < NUM_CARDS && ch < IN_CH) in_bits[card][ch] = t.bit_value;
      end
      OP_SET_OVL: begin
        if (t.card_number < NUM_CARDS) ovl_ok[t.card_number] = !t.bit_value;
      end
      OP_RD_IN: r.read_bit = input_level(t.terminal);
      OP_RD_OUT: r.read_bit = output_level(t.terminal);
      OP_PENDANT: begin
        in_bits[0][IN_STOP_N] = !t.buttons[0];
        in_bits[0][IN_START] = t.buttons[1];
        in_bits[0][IN_RAPID] = t.buttons[2];
        in_bits[0][IN_MANUAL] = t.buttons[3];
        in_bits[0][IN_FEED_EN] = t.buttons[4];
        in_bits[0][IN_FEEDBACK] = out_bits[0][OUT_FB_CH];
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------- result side ----------------
  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (io_results_due.size() == 0) begin
        flag_error($sformatf("unexpected result read_bit %0b accepted %0b",
                             out_data.read_bit, out_data.accepted));
      end else begin
        want = io_results_due.pop_front();
        if (out_data.read_bit !== want.read_bit || out_data.accepted !== want.accepted)
          flag_error($sformatf("result %0d: read_bit exp %0b got %0b, accepted exp %0b got %0b",
                               n_checked, want.read_bit, out_data.read_bit,
                               want.accepted, out_data.accepted));
      end
      n_checked++;
    end
  end

  // ---------------- stimulus side ----------------
  task automatic send_item(input in_item_t t);
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    io_results_due.push_back(backplane_step(t));
    n_sent++;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (io_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_windows(input logic [15:0] ib, il, ob, ol);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_IN_BASE;
    cfg_data <= ib;
    @(posedge clk);
    cfg_index <= REG_IN_LAST;
    cfg_data <= il;
    @(posedge clk);
    cfg_index <= REG_OUT_BASE;
    cfg_data <= ob;
    @(posedge clk);
    cfg_index <= REG_OUT_LAST;
    cfg_data <= ol;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_in_base = ib;
    win_in_last = il;
    win_out_base = ob;
    win_out_last = ol;
    n_settings++;
  endtask

  function automatic in_item_t mk(input logic [2:0] op, input logic [15:0] addr,
                                  input logic [7:0] term, input logic [1:0] card,
                                  input logic bv, input logic [4:0] btn);
    in_item_t t;
    t.op = op_t'(op);
    t.cru_addr = addr;
    t.terminal = term;
    t.card_number = card;
    t.bit_value = bv;
    t.buttons = btn;
    return t;
  endfunction

  function automatic logic [15:0] pick_addr(input logic [15:0] lo, hi,
                                            input int unsigned span);
    int unsigned r, top;
    r = $urandom_range(0, 9);
    if (r == 0 || lo > hi) return 16'($urandom_range(0, 65535));
    if (r == 1) return lo - 16'd1;
    if (r == 2) return hi + 16'd1;
    top = (hi - lo < span) ? hi : lo + span - 1;
    return 16'($urandom_range(lo, top));
  endfunction

  function automatic in_item_t random_item();
    in_item_t t;
    int unsigned r;
    t = mk(OP_NONE, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
           2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
    r = $urandom_range(0, 19);
    if (r < 5) begin
      t.op = OP_CRU_RD;
      t.cru_addr = pick_addr(win_in_base, win_in_last, 256);
    end else if (r < 10) begin
      t.op = OP_CRU_WR;
      t.cru_addr = pick_addr(win_out_base, win_out_last, 128);
    end else if (r < 12) t.op = OP_SET_IN;
    else if (r < 13) t.op = OP_SET_OVL;
    else if (r < 15) t.op = OP_RD_IN;
    else if (r < 17) t.op = OP_RD_OUT;
    else if (r < 19) t.op = OP_PENDANT;
    return t;
  endfunction

  // ---------------- tests ----------------
  task automatic test_reset_state();
    send_item(mk(OP_RD_IN, 16'd0, 8'd18, 2'd0, 1'b0, 5'd0));
    send_item(mk(OP_RD_IN, 16'd0, 8'd23, 2'd0, 1'b0, 5'd0));
    send_item(mk(OP_CRU_RD, 16'd20, 8'd0, 2'd0, 1'b0, 5'd0));
    send_item(mk(OP_RD_IN, 16'd0, 8'd255, 2'd0, 1'b0, 5'd0));
  endtask

  task automatic test_feedback_and_strobe();
    send_item(mk(OP_CRU_WR, 16'd6, 8'd0, 2'd0, 1'b1, 5'd0));
    send_item(mk(OP_CRU_RD, 16'd20, 8'd0, 2'd0, 1'b0, 5'd0));
    send_item(mk(OP_RD_OUT, 16'd0, 8'd6, 2'd0, 1'b0, 5'd0));
    send_item(mk(OP_SET_OVL, 16'd0, 8'd0, 2'd3, 1'b1, 5'd0));
    send_item(mk(OP_CRU_RD, 16'd255, 8'd0, 2'd0, 1'b0, 5'd0));
    send_item(mk(OP_CRU_WR, 16'd127, 8'd0, 2'd0, 1'b0, 5'd0));
    send_item(mk(OP_RD_IN, 16'd0, 8'd255, 2'd0, 1'b0, 5'd0));
    send_item(mk(OP_CRU_WR, 16'd127, 8'd0, 2'd0, 1'b1, 5'd0));
    send_item(mk(OP_RD_IN, 16'd0, 8'd255, 2'd0, 1'b0, 5'd0));
    send_item(mk(OP_RD_OUT, 16'd0, 8'd31, 2'd0, 1'b0, 5'd0));
    send_item(mk(OP_SET_OVL, 16'd0, 8'd0, 2'd0, 1'b0, 5'd0));
  endtask

  task automatic test_terminals_and_pendant();
    send_item(mk(OP_SET_IN, 16'd0, 8'd62, 2'd0, 1'b1, 5'd0));
    send_item(mk(OP_RD_IN, 16'd0, 8'd62, 2'd0, 1'b0, 5'd0));
    send_item(mk(OP_SET_IN, 16'd0, 8'd127, 2'd0, 1'b0, 5'd0));
    send_item(mk(OP_RD_IN, 16'd0, 8'd127, 2'd0, 1'b0, 5'd0));
    send_item(mk(OP_PENDANT, 16'd0, 8'd0, 2'd0, 1'b0, 5'h1f));
    send_item(mk(OP_RD_IN, 16'd0, 8'd23, 2'd0, 1'b0, 5'd0));
    send_item(mk(OP_PENDANT, 16'hffff, 8'hff, 2'd3, 1'b1, 5'd0));
    send_item(mk(OP_RD_IN, 16'd0, 8'd20, 2'd0, 1'b0, 5'd0));
    send_item(mk(OP_NONE, 16'hffff, 8'hff, 2'd3, 1'b1, 5'h1f));
  endtask

  task automatic test_refused_access();
    send_item(mk(OP_CRU_RD, 16'd256, 8'd0, 2'd0, 1'b0, 5'd0));
    send_item(mk(OP_CRU_WR, 16'd128, 8'd0, 2'd0, 1'b1, 5'd0));
    send_item(mk(OP_CRU_WR, 16'hffff, 8'd0, 2'd0, 1'b1, 5'd0));
  endtask

  task automatic test_window_extremes();
    set_windows(16'd0, 16'hffff, 16'd0, 16'hffff);
    send_item(mk(OP_CRU_RD, 16'hffff, 8'd0, 2'd0, 1'b0, 5'd0));
    send_item(mk(OP_CRU_WR, 16'hffff, 8'd0, 2'd0, 1'b1, 5'd0));
    send_item(mk(OP_CRU_RD, 16'd300, 8'd0, 2'd0, 1'b0, 5'd0));
    set_windows(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_item(mk(OP_CRU_WR, 16'hffff, 8'd0, 2'd0, 1'b1, 5'd0));
    send_item(mk(OP_CRU_RD, 16'hffff, 8'd0, 2'd0, 1'b0, 5'd0));
    send_item(mk(OP_CRU_RD, 16'd0, 8'd0, 2'd0, 1'b0, 5'd0));
    set_windows(16'd200, 16'd100, 16'd500, 16'd400);
    send_item(mk(OP_CRU_RD, 16'd150, 8'd0, 2'd0, 1'b0, 5'd0));
    send_item(mk(OP_CRU_WR, 16'd450, 8'd0, 2'd0, 1'b1, 5'd0));
  endtask

  task automatic test_random_traffic();
    logic [15:0] ib, ob;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_windows(IN_BASE_RST, IN_LAST_RST, OUT_BASE_RST, OUT_LAST_RST);
        1: set_windows(16'd0, 16'hffff, 16'd0, 16'hffff);
        4: set_windows(16'hff00, 16'hffff, 16'hff80, 16'hffff);
        default: begin
          ib = 16'($urandom_range(0, 65000));
          ob = 16'($urandom_range(0, 65000));
          set_windows(ib, ib + 16'($urandom_range(0, 400)), ob, ob + 16'($urandom_range(0, 200)));
        end
      endcase
      gap_pct = (phase == 1) ? 0 : 10 * $urandom_range(1, 5);
      stall_pct = (phase == 1) ? 0 : 10 * $urandom_range(1, 5);
      quiet = (phase == 5);
      repeat (108) send_item(random_item());
    end
  endtask

  initial begin
    clear_backplane();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_feedback_and_strobe();
    test_terminals_and_pendant();
    test_refused_access();
    test_window_extremes();
    test_random_traffic();
    drain();
    repeat (10) @(posedge clk);
    if (io_results_due.size() != 0)
      flag_error($sformatf("%0d results never arrived", io_results_due.size()));
    $display("Sent %0d transactions under %0d window settings, checked %0d results, %0d errors",
             n_sent, n_settings, n_checked, n_errors);
    if (n_errors == 0) begin
      $display("PASS cru_bit_io_backplane");
    end else begin
      $display("FAIL cru_bit_io_backplane");
    end
    $finish;
  end

endmodule
